// ===== src/ccr_pkg.sv =====
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared types and constants for the closed-loop Catmull-Rom evaluator.
// ----------------------------------------------------------------------------
package ccr_pkg;

    localparam int CoordW           = 32;
    localparam int ParamW           = 16;
    localparam int CountW           = 7;
    localparam int IndexW           = 6;
    localparam int FracW            = 16;
    localparam int MaxPointsDefault = 64;
    localparam int MinPoints        = 3;

    localparam logic ReqWrite = 1'b0;
    localparam logic ReqEval  = 1'b1;

    typedef struct packed {
        logic                     req_type;
        logic [IndexW-1:0]        point_index;
        logic signed [CoordW-1:0] coord_x;
        logic signed [CoordW-1:0] coord_y;
        logic signed [CoordW-1:0] coord_z;
        logic [ParamW-1:0]        param_t;
    } in_item_t;

    typedef struct packed {
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic signed [CoordW-1:0] pos_z;
        logic                     pos_valid;
    } out_item_t;

endpackage

// ===== src/ccr_point_mem.sv =====
// ----------------------------------------------------------------------------
// ccr_point_mem
// One copy of the control point table: one write port, one registered read.
// ----------------------------------------------------------------------------
module ccr_point_mem #(
    parameter int AW = 6,
    parameter int DW = 96
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ccr_lane.sv =====
// ----------------------------------------------------------------------------
// ccr_lane
// Catmull-Rom cubic for one coordinate: coefficients, then a three-step
// Horner chain with one multiplier per stage, then halving and saturation.
// ----------------------------------------------------------------------------
module ccr_lane (
    input  logic                              clk,
    input  logic                              adv,
    input  logic signed [ccr_pkg::CoordW-1:0] p0,
    input  logic signed [ccr_pkg::CoordW-1:0] p1,
    input  logic signed [ccr_pkg::CoordW-1:0] p2,
    input  logic signed [ccr_pkg::CoordW-1:0] p3,
    input  logic [ccr_pkg::FracW-1:0]         u,
    output logic signed [ccr_pkg::CoordW-1:0] res
);

    localparam int HW = ccr_pkg::CoordW + 8;
    localparam int PW = HW + ccr_pkg::FracW + 1;
    localparam logic signed [PW-1:0] RndP = PW'(1) <<< (ccr_pkg::FracW - 1);
    localparam logic signed [HW-1:0] SatHi = HW'((64'sd1 <<< (ccr_pkg::CoordW - 1)) - 1);
    localparam logic signed [HW-1:0] SatLo = -(HW'(64'sd1 <<< (ccr_pkg::CoordW - 1)));

    logic signed [HW-1:0] e0, e1, e2, e3;
    logic signed [HW-1:0] a1_reg, b1_reg, c1_reg, d1_reg;
    logic signed [HW-1:0] a2_reg, b2_reg, c2_reg;
    logic signed [HW-1:0] a3_reg, b3_reg, a4_reg;
    logic [ccr_pkg::FracW-1:0] u1_reg, u2_reg, u3_reg;
    logic signed [PW-1:0] m1_reg, m2_reg, m3_reg;
    logic signed [PW-1:0] m1_next, m2_next, m3_next;
    logic signed [PW-1:0] r1, r2, r3;
    logic signed [HW-1:0] h1, h2, h3, hh;

    assign e0 = HW'(p0);
    assign e1 = HW'(p1);
    assign e2 = HW'(p2);
    assign e3 = HW'(p3);

    // floor((v + half) / 2^16) for each product
    assign r1 = (m1_reg + RndP) >>> ccr_pkg::FracW;
    assign r2 = (m2_reg + RndP) >>> ccr_pkg::FracW;
    assign r3 = (m3_reg + RndP) >>> ccr_pkg::FracW;

    assign m1_next = PW'(d1_reg) * PW'($signed({1'b0, u1_reg}));
    assign h1      = HW'(r1) + c2_reg;
    assign m2_next = PW'(h1) * PW'($signed({1'b0, u2_reg}));
    assign h2      = HW'(r2) + b3_reg;
    assign m3_next = PW'(h2) * PW'($signed({1'b0, u3_reg}));
    assign h3      = HW'(r3) + a4_reg;
    assign hh      = (h3 + HW'(1)) >>> 1;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg <= e1 <<< 1;
            b1_reg <= e2 - e0;
            c1_reg <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
            d1_reg <= (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;
            u1_reg <= u;

            m1_reg <= m1_next;
            c2_reg <= c1_reg;
            b2_reg <= b1_reg;
            a2_reg <= a1_reg;
            u2_reg <= u1_reg;

            m2_reg <= m2_next;
            b3_reg <= b2_reg;
            a3_reg <= a2_reg;
            u3_reg <= u2_reg;

            m3_reg <= m3_next;
            a4_reg <= a3_reg;
        end
    end

    always_comb
    begin
        if (hh > SatHi)
        begin
            res = ccr_pkg::CoordW'(SatHi);
        end
        else if (hh < SatLo)
        begin
            res = ccr_pkg::CoordW'(SatLo);
        end
        else
        begin
            res = ccr_pkg::CoordW'(hh);
        end
    end

endmodule

// ===== src/closed_catmull_rom_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// closed_catmull_rom_evaluator_top
// Closed-loop uniform Catmull-Rom evaluator over a table of 3D points.
// ----------------------------------------------------------------------------
// Takes one item per clock while no result waits at a stalled output: write
// items load all four copies of the point table, evaluate items read the four
// neighbouring points in the same cycle, one from each copy, so consecutive
// evaluations never contend for a port. A result passes the table read, the
// coefficient register and each step of the three-step Horner chain (one
// multiplier stage per step) before it reaches the output register.
// Write items give no result. The whole pipeline holds while a result waits
// at the output and the far side stalls.
module closed_catmull_rom_evaluator_top #(
    parameter int MAX_POINTS = ccr_pkg::MaxPointsDefault
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  ccr_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output ccr_pkg::out_item_t          out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ccr_pkg::CountW-1:0]  cfg_data
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int NW    = $clog2(MAX_POINTS + 1);
    localparam int SW    = ccr_pkg::ParamW + NW;
    localparam int DW    = 3 * ccr_pkg::CoordW;
    localparam int DEPTH = 5;

    logic [ccr_pkg::CountW-1:0] count_reg;
    logic [NW-1:0]              n;
    logic [SW-1:0]              s;
    logic [NW:0]                seg, i0, i2, i3, segp2;
    logic                       adv, acc, wr_en, rd_en;
    logic [AW-1:0]              waddr;
    logic [DW-1:0]              wdata;
    logic [DW-1:0]              rd0, rd1, rd2, rd3;
    logic [ccr_pkg::FracW-1:0]  u_reg;
    logic [DEPTH-1:0]           ev_reg, ok_reg;
    logic signed [ccr_pkg::CoordW-1:0] rx, ry, rz;
    logic                       out_valid_reg;
    ccr_pkg::out_item_t         out_reg, out_next;

    assign cfg_ready = 1'b1;
    assign adv       = !(out_valid_reg && out_stall);
    assign in_stall  = !adv;
    assign acc       = in_valid && adv;

    // effective count, clamped to the table size
    assign n = (32'(count_reg) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(count_reg);

    assign s     = SW'(in_data.param_t) * SW'(n);
    assign seg   = (NW+1)'(s >> ccr_pkg::FracW);
    assign segp2 = seg + (NW+1)'(2);
    assign i0    = (seg == '0) ? (NW+1)'(n) - (NW+1)'(1) : seg - (NW+1)'(1);
    assign i2    = (seg + (NW+1)'(1) == (NW+1)'(n)) ? '0 : seg + (NW+1)'(1);
    assign i3    = (segp2 >= (NW+1)'(n)) ? segp2 - (NW+1)'(n) : segp2;

    assign wr_en = acc && (in_data.req_type == ccr_pkg::ReqWrite)
                   && (32'(in_data.point_index) < MAX_POINTS);
    assign rd_en = adv;
    assign waddr = AW'(32'(in_data.point_index));
    assign wdata = {in_data.coord_x, in_data.coord_y, in_data.coord_z};

    ccr_point_mem #(.AW(AW), .DW(DW)) u_mem0 (
        .clk(clk), .we(wr_en), .waddr(waddr), .wdata(wdata),
        .re(rd_en), .raddr(i0[AW-1:0]), .rdata(rd0)
    );
    ccr_point_mem #(.AW(AW), .DW(DW)) u_mem1 (
        .clk(clk), .we(wr_en), .waddr(waddr), .wdata(wdata),
        .re(rd_en), .raddr(seg[AW-1:0]), .rdata(rd1)
    );
    ccr_point_mem #(.AW(AW), .DW(DW)) u_mem2 (
        .clk(clk), .we(wr_en), .waddr(waddr), .wdata(wdata),
        .re(rd_en), .raddr(i2[AW-1:0]), .rdata(rd2)
    );
    ccr_point_mem #(.AW(AW), .DW(DW)) u_mem3 (
        .clk(clk), .we(wr_en), .waddr(waddr), .wdata(wdata),
        .re(rd_en), .raddr(i3[AW-1:0]), .rdata(rd3)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u_reg <= s[ccr_pkg::FracW-1:0];
        end
    end

    ccr_lane u_lane_x (
        .clk(clk), .adv(adv),
        .p0(rd0[3*ccr_pkg::CoordW-1 -: ccr_pkg::CoordW]),
        .p1(rd1[3*ccr_pkg::CoordW-1 -: ccr_pkg::CoordW]),
        .p2(rd2[3*ccr_pkg::CoordW-1 -: ccr_pkg::CoordW]),
        .p3(rd3[3*ccr_pkg::CoordW-1 -: ccr_pkg::CoordW]),
        .u(u_reg), .res(rx)
    );
    ccr_lane u_lane_y (
        .clk(clk), .adv(adv),
        .p0(rd0[2*ccr_pkg::CoordW-1 -: ccr_pkg::CoordW]),
        .p1(rd1[2*ccr_pkg::CoordW-1 -: ccr_pkg::CoordW]),
        .p2(rd2[2*ccr_pkg::CoordW-1 -: ccr_pkg::CoordW]),
        .p3(rd3[2*ccr_pkg::CoordW-1 -: ccr_pkg::CoordW]),
        .u(u_reg), .res(ry)
    );
    ccr_lane u_lane_z (
        .clk(clk), .adv(adv),
        .p0(rd0[ccr_pkg::CoordW-1:0]),
        .p1(rd1[ccr_pkg::CoordW-1:0]),
        .p2(rd2[ccr_pkg::CoordW-1:0]),
        .p3(rd3[ccr_pkg::CoordW-1:0]),
        .u(u_reg), .res(rz)
    );

    // result fields: zero with valid cleared when the loop is too short
    always_comb
    begin
        if (ok_reg[DEPTH-1])
        begin
            out_next.pos_x     = rx;
            out_next.pos_y     = ry;
            out_next.pos_z     = rz;
            out_next.pos_valid = 1'b1;
        end
        else
        begin
            out_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ev_reg        <= '0;
            ok_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
            if (adv)
            begin
                ev_reg <= {ev_reg[DEPTH-2:0], acc && (in_data.req_type == ccr_pkg::ReqEval)};
                ok_reg <= {ok_reg[DEPTH-2:0], 32'(n) >= ccr_pkg::MinPoints};
                out_valid_reg <= ev_reg[DEPTH-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
